// ===== rtl/tccw_pkg.sv =====
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and codes of the text console cell writer: request codes,
// character codes, the command that travels from the front to the back, and
// the state of the back-end sequencer.
// ----------------------------------------------------------------------------
package tccw_pkg;

   // Field widths of the request and response beats
   localparam int TYPE_W = 2;
   localparam int CHAR_W = 8;
   localparam int ROWF_W = 5;
   localparam int COLF_W = 7;

   // Request types
   localparam logic [TYPE_W-1:0] REQ_PUT   = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_READ  = 2'd2;

   // Character codes
   localparam logic [CHAR_W-1:0] CODE_EMPTY = 8'd0;
   localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CODE_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CODE_NL    = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CODE_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] PRINT_LO   = 8'd32;
   localparam logic [CHAR_W-1:0] PRINT_HI   = 8'd127;

   // Tab stops every 4 columns: low bits of the column that must be zero
   localparam int TAB_STOP_W = 2;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   typedef enum logic [2:0] {
      OP_IGNORE,
      OP_PRINT,
      OP_NEWLINE,
      OP_RETURN,
      OP_BACKSPACE,
      OP_TAB,
      OP_CLEAR,
      OP_READ
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type          op;
      logic [CHAR_W-1:0]   code;
      logic                rd_ok;
      logic [ROWF_W-1:0]   rd_row;
      logic [COLF_W-1:0]   rd_col;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ROWCLR,
      ST_RDWAIT,
      ST_RESP
   } back_state_type;

endpackage

// ===== rtl/tccw_queue.sv =====
// ----------------------------------------------------------------------------
// tccw_queue
// Two-entry command queue between the classifying front and the executing
// back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module tccw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tccw_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output tccw_pkg::cmd_type pop_cmd,
   output logic [tccw_pkg::QUEUE_CNT_W-1:0] level
);
   import tccw_pkg::*;

   cmd_type                 slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  level_ff, level_in;

   assign full    = (level_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty   = (level_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];
   assign level   = level_ff;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      level_in  = level_ff;
      if (push && !pop) begin
         level_in = level_ff + 1'b1;
      end else if (pop && !push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/tccw_front.sv =====
// ----------------------------------------------------------------------------
// tccw_front
// Request front end: takes request beats while the queue has room, decodes
// the request type and character code into a command, and range-checks
// read coordinates.
// ----------------------------------------------------------------------------
module tccw_front #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tccw_pkg::TYPE_W-1:0] req_type,
   input  logic [tccw_pkg::CHAR_W-1:0] req_char_code,
   input  logic [tccw_pkg::ROWF_W-1:0] req_read_row,
   input  logic [tccw_pkg::COLF_W-1:0] req_read_col,
   input  logic                        q_full,
   output logic                        q_push,
   output tccw_pkg::cmd_type           q_cmd
);
   import tccw_pkg::*;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // Classify the request
   always_comb begin
      q_cmd.op     = OP_IGNORE;
      q_cmd.code   = req_char_code;
      q_cmd.rd_row = req_read_row;
      q_cmd.rd_col = req_read_col;
      q_cmd.rd_ok  = (int'(req_read_row) < ROWS) && (int'(req_read_col) < COLS);
      unique case (req_type)
         REQ_PUT: begin
            priority if (req_char_code == CODE_NL) begin
               q_cmd.op = OP_NEWLINE;
            end else if (req_char_code == CODE_CR) begin
               q_cmd.op = OP_RETURN;
            end else if (req_char_code == CODE_BS) begin
               q_cmd.op = OP_BACKSPACE;
            end else if (req_char_code == CODE_TAB) begin
               q_cmd.op = OP_TAB;
            end else if (req_char_code >= PRINT_LO && req_char_code < PRINT_HI) begin
               q_cmd.op = OP_PRINT;
            end else begin
               q_cmd.op = OP_IGNORE;
            end
         end
         REQ_CLEAR: q_cmd.op = OP_CLEAR;
         REQ_READ:  q_cmd.op = OP_READ;
         default:   q_cmd.op = OP_IGNORE;
      endcase
   end

endmodule

// ===== rtl/tccw_back.sv =====
// ----------------------------------------------------------------------------
// tccw_back
// Command executor: holds the cell memory, per-row valid bits, top-row
// pointer and cursor, runs one queued command at a time and drives the
// response register.
// ----------------------------------------------------------------------------
module tccw_back #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  tccw_pkg::cmd_type           q_cmd,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tccw_pkg::CHAR_W-1:0] rsp_cell_char,
   output logic [tccw_pkg::ROWF_W-1:0] rsp_cursor_row_out,
   output logic [tccw_pkg::COLF_W-1:0] rsp_cursor_col_out,
   output logic                        rsp_scrolled
);
   import tccw_pkg::*;

   localparam int ROW_W     = $clog2(ROWS);
   localparam int COLA_W    = $clog2(COLS);
   localparam int CCOL_W    = $clog2(COLS + 1);
   localparam int ADDR_W    = ROW_W + COLA_W;
   localparam int MEM_DEPTH = ROWS * (1 << COLA_W);

   back_state_type          state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [ROW_W-1:0]        top_ff, top_in;
   logic [ROW_W-1:0]        crow_ff, crow_in;
   logic [CCOL_W-1:0]       ccol_ff, ccol_in;
   logic [ROWS-1:0]         row_valid_ff, row_valid_in;
   logic [COLA_W-1:0]       sweep_ff, sweep_in;
   logic                    scr_ff, scr_in;
   logic [CHAR_W-1:0]       cell_ff, cell_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]       rsp_cell_ff, rsp_cell_in;
   logic [ROWF_W-1:0]       rsp_row_ff, rsp_row_in;
   logic [COLF_W-1:0]       rsp_col_ff, rsp_col_in;
   logic                    rsp_scr_ff, rsp_scr_in;

   logic [CHAR_W-1:0]       mem [MEM_DEPTH];
   logic                    mem_we, mem_re;
   logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
   logic [CHAR_W-1:0]       mem_wdata;
   logic [CHAR_W-1:0]       mem_rdata_ff;

   logic [ROW_W:0]          cur_sum, rd_sum;
   logic [ROW_W-1:0]        cur_phys, rd_phys;
   logic                    cur_valid, col_in_range, adv;
   logic [CCOL_W-1:0]       ccol_inc, ccol_dec;

   // Map screen rows to physical rows through the top-row pointer
   always_comb begin
      cur_sum  = (ROW_W+1)'(top_ff) + (ROW_W+1)'(crow_ff);
      cur_phys = (cur_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(cur_sum - (ROW_W+1)'(ROWS))
                                                : ROW_W'(cur_sum);
      rd_sum   = (ROW_W+1)'(top_ff) + (ROW_W+1)'(cmd_ff.rd_row);
      rd_phys  = (rd_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(rd_sum - (ROW_W+1)'(ROWS))
                                               : ROW_W'(rd_sum);
   end

   assign cur_valid    = row_valid_ff[cur_phys];
   assign col_in_range = (ccol_ff < CCOL_W'(COLS));
   assign ccol_inc     = ccol_ff + 1'b1;
   assign ccol_dec     = ccol_ff - 1'b1;
   assign mem_raddr    = {rd_phys, COLA_W'(cmd_ff.rd_col)};

   // Sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      top_in       = top_ff;
      crow_in      = crow_ff;
      ccol_in      = ccol_ff;
      row_valid_in = row_valid_ff;
      sweep_in     = sweep_ff;
      scr_in       = scr_ff;
      cell_in      = cell_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = {cur_phys, ccol_ff[COLA_W-1:0]};
      mem_wdata    = CODE_EMPTY;
      adv          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cell_in  = rsp_cell_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_scr_in   = rsp_scr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               scr_in   = 1'b0;
               cell_in  = CODE_EMPTY;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            state_in = ST_RESP;
            unique case (cmd_ff.op)
               OP_CLEAR: begin
                  row_valid_in = '0;
                  top_in       = '0;
                  crow_in      = '0;
                  ccol_in      = '0;
               end
               OP_READ: begin
                  if (cmd_ff.rd_ok && row_valid_ff[rd_phys]) begin
                     mem_re   = 1'b1;
                     state_in = ST_RDWAIT;
                  end
               end
               OP_RETURN: begin
                  ccol_in = '0;
               end
               OP_NEWLINE: begin
                  // an empty row already reads as empty: no write needed
                  if (col_in_range && cur_valid) begin
                     mem_we = 1'b1;
                  end
                  ccol_in = '0;
                  adv     = 1'b1;
               end
               OP_BACKSPACE: begin
                  if (ccol_ff != '0) begin
                     if (!cur_valid) begin
                        sweep_in = '0;
                        state_in = ST_ROWCLR;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = {cur_phys, ccol_dec[COLA_W-1:0]};
                        mem_wdata = CODE_SPACE;
                        ccol_in   = ccol_dec;
                     end
                  end
               end
               OP_TAB: begin
                  // one space per cycle, after any row sweep, until a tab stop or the right edge
                  if (col_in_range) begin
                     if (!cur_valid) begin
                        sweep_in = '0;
                        state_in = ST_ROWCLR;
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = CODE_SPACE;
                        ccol_in   = ccol_inc;
                        if (ccol_inc[TAB_STOP_W-1:0] != '0 && ccol_inc != CCOL_W'(COLS)) begin
                           state_in = ST_EXEC;
                        end
                     end
                  end
               end
               OP_PRINT: begin
                  if (col_in_range) begin
                     if (!cur_valid) begin
                        sweep_in = '0;
                        state_in = ST_ROWCLR;
                     end else begin
                        mem_we    = 1'b1;
                        mem_wdata = cmd_ff.code;
                        if (ccol_inc == CCOL_W'(COLS)) begin
                           ccol_in = '0;
                           adv     = 1'b1;
                        end else begin
                           ccol_in = ccol_inc;
                        end
                     end
                  end
               end
               OP_IGNORE: begin
               end
               default: begin
               end
            endcase

            // Advance the row; scroll at the bottom by retiring the top row
            if (adv) begin
               if (crow_ff == ROW_W'(ROWS - 1)) begin
                  row_valid_in[top_ff] = 1'b0;
                  top_in = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + 1'b1;
                  scr_in = 1'b1;
               end else begin
                  crow_in = crow_ff + 1'b1;
               end
            end
         end

         ST_ROWCLR: begin
            // empty the cursor row before its first write
            mem_we    = 1'b1;
            mem_waddr = {cur_phys, sweep_ff};
            mem_wdata = CODE_EMPTY;
            if (sweep_ff == COLA_W'(COLS - 1)) begin
               row_valid_in[cur_phys] = 1'b1;
               state_in = ST_EXEC;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end

         ST_RDWAIT: begin
            cell_in  = mem_rdata_ff;
            state_in = ST_RESP;
         end

         ST_RESP: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cell_in  = cell_ff;
               rsp_row_in   = ROWF_W'(crow_ff);
               rsp_col_in   = COLF_W'(ccol_ff);
               rsp_scr_in   = scr_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         top_ff       <= '0;
         crow_ff      <= '0;
         ccol_ff      <= '0;
         row_valid_ff <= '0;
         sweep_ff     <= '0;
         scr_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         crow_ff      <= crow_in;
         ccol_ff      <= ccol_in;
         row_valid_ff <= row_valid_in;
         sweep_ff     <= sweep_in;
         scr_ff       <= scr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      cell_ff     <= cell_in;
      rsp_cell_ff <= rsp_cell_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   // Cell memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem[mem_raddr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_cell_char      = rsp_cell_ff;
   assign rsp_cursor_row_out = rsp_row_ff;
   assign rsp_cursor_col_out = rsp_col_ff;
   assign rsp_scrolled       = rsp_scr_ff;

endmodule

// ===== rtl/text_console_cell_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_writer_core
// Character-cell text console: a grid of character codes with a cursor,
// taking put-character, clear-screen and read-cell requests.
//
//   channel  ports   direction  beat
//   request  req_*   in         type, character code, read row, read column
//   response rsp_*   out        cell code, cursor row, cursor column, scrolled
//
// A request passes through the back-end steps fetch, execute and respond;
// a cell read adds a wait for the registered memory read, and a tab stays
// in execute and writes one space per cycle, apart from any row sweep.
// The first write into an empty row first sweeps that row empty in memory.
// Reset empties the screen at once through per-row valid bits; no memory
// pass follows reset. Clear and scroll also work on those valid bits.
// A two-entry queue keeps taking requests while a response is held.
// ----------------------------------------------------------------------------
module text_console_cell_writer_core #(
   parameter int ROWS = 25,
   parameter int COLS = 80
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tccw_pkg::TYPE_W-1:0] req_type,
   input  logic [tccw_pkg::CHAR_W-1:0] req_char_code,
   input  logic [tccw_pkg::ROWF_W-1:0] req_read_row,
   input  logic [tccw_pkg::COLF_W-1:0] req_read_col,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tccw_pkg::CHAR_W-1:0] rsp_cell_char,
   output logic [tccw_pkg::ROWF_W-1:0] rsp_cursor_row_out,
   output logic [tccw_pkg::COLF_W-1:0] rsp_cursor_col_out,
   output logic                        rsp_scrolled
);
   import tccw_pkg::*;

   logic                   q_push, q_pop, q_full, q_empty;
   cmd_type                push_cmd, pop_cmd;
   logic [QUEUE_CNT_W-1:0] q_level;

   tccw_front #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_cmd         (push_cmd)
   );

   tccw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .pop_cmd  (pop_cmd),
      .level    (q_level)
   );

   tccw_back #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (q_empty),
      .q_cmd              (pop_cmd),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .rsp_scrolled       (rsp_scrolled)
   );

   // An accepted request beat always finds room in the queue
   a_accept_has_room: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (q_level < QUEUE_CNT_W'(QUEUE_DEPTH)))
      else $error("request beat accepted with the queue full");

   // Queue level tracks a push without a pop
   a_level_tracks_push: assert property (@(posedge clock) disable iff (reset)
      (q_push && !q_pop) |=> (q_level == $past(q_level) + 1'b1))
      else $error("queue level did not advance on push");

   // A scrolling beat reports the cursor on the bottom row
   a_scroll_bottom_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |-> (rsp_cursor_row_out == ROWF_W'(ROWS - 1)))
      else $error("scroll reported with the cursor off the bottom row");

   // The back end never pops an empty queue
   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command popped from an empty queue");

endmodule
